// ===== sv/q8bdcf_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and control types for the block-quantized dot product with fold.
package q8bdcf_pkg;

  localparam int BLOCK_LEN_DEF = 32;
  localparam int FOLD_NORM     = 41;
  localparam int MUL_STEPS     = 8;

  typedef logic [2:0] step_t;

  typedef struct packed {
    logic  load;
    logic  mac;
    logic  prep;
    logic  mul_en;
    step_t mul_step;
    logic  clr_ps;
    logic  emit;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== sv/q8bdcf_ctrl.sv =====
`timescale 1ns / 1ps
// Controller sequencing element accumulation, block folds and result hand-off.
module q8bdcf_ctrl
  import q8bdcf_pkg::*;
#(
  parameter int BLOCK_LEN = BLOCK_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam int CW = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_PREP,
    S_MUL,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t        state;
  logic [CW-1:0] cnt;
  step_t         step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      step  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_MAC;
        end
        S_MAC: begin
          if (cnt == CW'(BLOCK_LEN - 1) || status.last) begin
            cnt   <= '0;
            state <= S_PREP;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= S_IDLE;
          end
        end
        S_PREP: begin
          step  <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          step <= step + 1'b1;
          if (step == step_t'(MUL_STEPS - 1)) state <= S_DRAIN;
        end
        S_DRAIN: begin
          state <= status.last ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (!status.out_busy) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == S_IDLE) && in_valid;
    cmd.mac      = (state == S_MAC);
    cmd.prep     = (state == S_PREP);
    cmd.mul_en   = (state == S_MUL);
    cmd.mul_step = step;
    cmd.clr_ps   = (state == S_DRAIN);
    cmd.emit     = (state == S_EMIT) && !status.out_busy;
  end

endmodule

// ===== sv/q8bdcf_dp.sv =====
`timescale 1ns / 1ps
// Datapath: partial sums, shared fold multiplier, row accumulators and output register.
module q8bdcf_dp
  import q8bdcf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  input  logic               cfg_valid,
  input  logic               compute_b,
  input  logic signed [7:0]  weight_code,
  input  logic signed [63:0] act_a,
  input  logic signed [63:0] act_b,
  input  logic signed [31:0] block_coef_a,
  input  logic signed [31:0] block_coef_b,
  input  logic               row_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] acc_a,
  output logic signed [63:0] acc_b
);

  logic               comp_b;
  logic signed [7:0]  w_q;
  logic [63:0]        xa_q;
  logic [63:0]        xb_q;
  logic signed [31:0] ba_q;
  logic signed [31:0] bb_q;
  logic               last_q;
  logic [63:0]        part_sum_a;
  logic [63:0]        part_sum_b;
  logic [63:0]        norm_b;
  logic [63:0]        sum_ab;
  logic [63:0]        row_acc_a;
  logic [63:0]        row_acc_b;
  logic [63:0]        prod;
  logic               add_en;
  step_t              add_step;

  logic signed [71:0] wa_full;
  logic signed [71:0] wb_full;
  logic [63:0]        mul_src;
  logic [31:0]        mul_half;
  logic signed [32:0] mul_x;
  logic signed [32:0] mul_y;
  logic signed [65:0] mul_full;
  logic [63:0]        term;

  function automatic logic signed [71:0] weight_ext(input logic signed [7:0] w);
    return 72'(w);
  endfunction

  assign wa_full = 72'(weight_ext(w_q)) * 72'(signed'(xa_q));
  assign wb_full = 72'(weight_ext(w_q)) * 72'(signed'(xb_q));

  // Step bit 0 picks the high half, bit 1 the Bb coefficient, bit 2 the second accumulator.
  always_comb begin
    case ({cmd.mul_step[2], cmd.mul_step[1]})
      2'b00:   mul_src = part_sum_a;
      2'b01:   mul_src = norm_b;
      2'b10:   mul_src = part_sum_b;
      default: mul_src = sum_ab;
    endcase
    mul_half = cmd.mul_step[0] ? mul_src[63:32] : mul_src[31:0];
    mul_x    = cmd.mul_step[1] ? 33'(bb_q) : 33'(ba_q);
    mul_y    = signed'({1'b0, mul_half});
    mul_full = 66'(mul_x) * 66'(mul_y);
    term     = add_step[0] ? {prod[31:0], 32'b0} : prod;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      comp_b    <= 1'b1;
      add_en    <= 1'b0;
      out_valid <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      if (cfg_valid) comp_b <= compute_b;
      add_en <= cmd.mul_en;
      if (cmd.load) last_q <= row_end;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      part_sum_a <= '0;
      part_sum_b <= '0;
      row_acc_a  <= '0;
      row_acc_b  <= '0;
    end else begin
      if (cmd.mac) begin
        part_sum_a <= part_sum_a + wa_full[63:0];
        part_sum_b <= part_sum_b + wb_full[63:0];
      end else if (cmd.clr_ps) begin
        part_sum_a <= '0;
        part_sum_b <= '0;
      end
      if (add_en) begin
        if (!add_step[2]) begin
          row_acc_a <= add_step[1] ? row_acc_a - term : row_acc_a + term;
        end else if (comp_b) begin
          row_acc_b <= row_acc_b + term;
        end
      end else if (cmd.emit) begin
        row_acc_a <= '0;
        row_acc_b <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_q  <= weight_code;
      xa_q <= act_a;
      xb_q <= act_b;
      ba_q <= block_coef_a;
      bb_q <= block_coef_b;
    end
    if (cmd.prep) begin
      norm_b <= part_sum_b * 64'(FOLD_NORM);
      sum_ab <= part_sum_a + part_sum_b;
    end
    if (cmd.mul_en) begin
      prod     <= mul_full[63:0];
      add_step <= cmd.mul_step;
    end
    if (cmd.emit) begin
      acc_a <= row_acc_a;
      acc_b <= comp_b ? row_acc_b : 64'd0;
    end
  end

  assign status.last     = last_q;
  assign status.out_busy = out_valid && !out_ready;

endmodule

// ===== sv/q8_block_dot_cyclotomic_fold.sv =====
`timescale 1ns / 1ps
// Top level of the block-quantized dot product with cyclotomic block fold.
// An element that does not close a block is accepted, then multiply-accumulated.
// An element that closes a block is then folded: a prep step, eight 32x32 multiplications through one
// shared multiplier, then a final accumulate; one that ends a row is then handed off.
// The row result is registered at the hand-off; a result still waiting stalls the hand-off.
// Synchronous reset clears the partial sums, the row accumulators and the element count and sets compute_b to 1.
module q8_block_dot_cyclotomic_fold
  import q8bdcf_pkg::*;
#(
  parameter int BLOCK_LEN = BLOCK_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               compute_b,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [7:0]  weight_code,
  input  logic signed [63:0] act_a,
  input  logic signed [63:0] act_b,
  input  logic signed [31:0] block_coef_a,
  input  logic signed [31:0] block_coef_b,
  input  logic               row_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] acc_a,
  output logic signed [63:0] acc_b
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  q8bdcf_ctrl #(
    .BLOCK_LEN (BLOCK_LEN)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  q8bdcf_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .compute_b    (compute_b),
    .weight_code  (weight_code),
    .act_a        (act_a),
    .act_b        (act_b),
    .block_coef_a (block_coef_a),
    .block_coef_b (block_coef_b),
    .row_end      (row_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .acc_a        (acc_a),
    .acc_b        (acc_b)
  );

endmodule

// ===== dv/tb_q8_block_dot_cyclotomic_fold.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the block-quantized dot product with cyclotomic fold.
module tb_q8_block_dot_cyclotomic_fold;
  import q8bdcf_pkg::*;

  localparam int BLOCK        = BLOCK_LEN_DEF;
  localparam int RANDOM_ITEMS = 750;
  localparam int MIN_ROWS     = 30;
  localparam int SETTLE_WAIT  = 20;
  localparam int TAIL_WAIT    = 30;
  localparam int CYCLE_LIMIT  = 600000;
  localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX64 = 64'h7fff_ffff_ffff_ffff;
  localparam logic [31:0] MIN32 = 32'h8000_0000;
  localparam logic [31:0] MAX32 = 32'h7fff_ffff;

  class fold_dot_model;
    bit        keep_b;
    int        elem_count;
    bit [63:0] part_a;
    bit [63:0] part_b;
    bit [63:0] row_a;
    bit [63:0] row_b;
    bit [63:0] due_a[$];
    bit [63:0] due_b[$];
    int        mismatches;
    int        rows_checked;

    function new();
      keep_b       = 1'b1;
      elem_count   = 0;
      part_a       = '0;
      part_b       = '0;
      row_a        = '0;
      row_b        = '0;
      mismatches   = 0;
      rows_checked = 0;
    endfunction

    function int pending();
      return due_a.size();
    endfunction

    function void note_element(logic [7:0] w, logic [63:0] xa, logic [63:0] xb,
                               logic [31:0] ba, logic [31:0] bb, logic last);
      bit [63:0] wx;
      bit [63:0] cx;
      bit [63:0] dx;
      bit [63:0] da;
      bit [63:0] db;
      wx = {{56{w[7]}}, w};
      cx = {{32{ba[31]}}, ba};
      dx = {{32{bb[31]}}, bb};
      part_a = part_a + wx * xa;
      part_b = part_b + wx * xb;
      elem_count++;
      if (elem_count >= BLOCK || last) begin
        da    = part_a;
        db    = part_b;
        row_a = row_a + cx * da - 64'(FOLD_NORM) * dx * db;
        if (keep_b) begin
          row_b = row_b + cx * db + dx * (da + db);
        end
        part_a     = '0;
        part_b     = '0;
        elem_count = 0;
      end
      if (last) begin
        due_a.push_back(row_a);
        due_b.push_back(keep_b ? row_b : 64'd0);
        row_a = '0;
        row_b = '0;
      end
    endfunction

    function void check_row(logic [63:0] a, logic [63:0] b);
      bit [63:0] ea;
      bit [63:0] eb;
      if (due_a.size() == 0) begin
        $error("result with no row pending: acc_a=%h acc_b=%h", a, b);
        mismatches++;
        return;
      end
      ea = due_a.pop_front();
      eb = due_b.pop_front();
      rows_checked++;
      if (a !== ea) begin
        $error("acc_a: expected %h, actual %h", ea, a);
        mismatches++;
      end
      if (b !== eb) begin
        $error("acc_b: expected %h, actual %h", eb, b);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               compute_b;
  logic               in_valid;
  logic               in_ready;
  logic signed [7:0]  weight_code;
  logic signed [63:0] act_a;
  logic signed [63:0] act_b;
  logic signed [31:0] block_coef_a;
  logic signed [31:0] block_coef_b;
  logic               row_end;
  logic               out_valid;
  logic               out_ready;
  logic signed [63:0] acc_a;
  logic signed [63:0] acc_b;

  fold_dot_model dot_model = new();
  bit            calm;
  int            cycles;
  int            cfg_writes;

  q8_block_dot_cyclotomic_fold #(
    .BLOCK_LEN(BLOCK)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .compute_b   (compute_b),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .weight_code (weight_code),
    .act_a       (act_a),
    .act_b       (act_b),
    .block_coef_a(block_coef_a),
    .block_coef_b(block_coef_b),
    .row_end     (row_end),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .acc_a       (acc_a),
    .acc_b       (acc_b)
  );

  initial begin
    clk = 1'b0;
  end

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // The receiver checks each row result and then stalls for a random number of cycles.
  initial begin
    int stall;
    out_ready = 1'b1;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        dot_model.check_row(acc_a, acc_b);
        stall = calm ? 0 : $urandom_range(0, 13);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  function automatic logic [63:0] pick64();
    case ($urandom_range(0, 7))
      0:       return MIN64;
      1:       return MAX64;
      2:       return 64'd0;
      3:       return '1;
      4:       return 64'($urandom_range(0, 200)) - 64'd100;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 7))
      0:       return MIN32;
      1:       return MAX32;
      2:       return 32'd0;
      3:       return '1;
      4:       return 32'($urandom_range(0, 20)) - 32'd10;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_weight();
    case ($urandom_range(0, 9))
      0:       return 8'h80;
      1:       return 8'h81;
      2:       return 8'h7f;
      3:       return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_item(logic [7:0] w, logic [63:0] xa, logic [63:0] xb,
                           logic [31:0] ba, logic [31:0] bb, logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    weight_code  <= w;
    act_a        <= xa;
    act_b        <= xb;
    block_coef_a <= ba;
    block_coef_b <= bb;
    row_end      <= last;
    do @(posedge clk); while (!in_ready);
    dot_model.note_element(w, xa, xb, ba, bb, last);
  endtask

  task automatic send_random(logic last);
    send_item(pick_weight(), pick64(), pick64(), pick32(), pick32(), last);
  endtask

  // Waits until every row has been reported and the fold pipeline has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (dot_model.pending() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_compute_b(logic value);
    settle();
    cfg_valid <= 1'b1;
    compute_b <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    dot_model.keep_b = value;
    cfg_writes++;
  endtask

  initial begin
    int n_items;
    int n_rows;
    int len;
    int split;
    int pick;
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    compute_b    = 1'b1;
    in_valid     = 1'b0;
    weight_code  = '0;
    act_a        = '0;
    act_b        = '0;
    block_coef_a = '0;
    block_coef_b = '0;
    row_end      = 1'b0;
    calm         = 1'b1;
    cfg_writes   = 0;
    n_items      = 0;
    n_rows       = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    write_compute_b(1'b1);
    send_item(8'h7f, MAX64, MIN64, MAX32, MIN32, 1'b1);
    send_item(8'h80, '1, 64'd1, '1, 32'd1, 1'b1);
    send_item(8'h81, MIN64, MAX64, MIN32, MAX32, 1'b1);
    send_item(8'h00, pick64(), pick64(), pick32(), pick32(), 1'b1);
    // A short row ends mid-block and folds with the coefficients of its last item.
    send_item(8'h01, 64'd5, 64'd7, 32'd3, '1, 1'b0);
    send_item(8'h80, MAX64, MIN64, 32'd9, 32'd9, 1'b0);
    send_item(8'h7f, MIN64, MAX64, MAX32, MAX32, 1'b1);
    write_compute_b(1'b0);
    send_item(8'hff, MIN64, MAX64, MIN32, MAX32, 1'b0);
    send_item(8'h80, MAX64, MAX64, MAX32, MIN32, 1'b1);
    // The register changes in the middle of a row in both directions.
    send_item(8'h7f, MAX64, MAX64, MAX32, MAX32, 1'b0);
    send_item(8'h80, MIN64, MIN64, MIN32, MIN32, 1'b0);
    write_compute_b(1'b1);
    send_item(8'h11, pick64(), pick64(), pick32(), pick32(), 1'b1);
    send_item(8'hc3, pick64(), pick64(), pick32(), pick32(), 1'b0);
    write_compute_b(1'b0);
    send_item(8'h3c, pick64(), pick64(), pick32(), pick32(), 1'b1);
    write_compute_b(1'b1);

    while (n_items < RANDOM_ITEMS || n_rows < MIN_ROWS) begin
      calm = ($urandom_range(0, 5) == 0);
      pick = $urandom_range(0, 19);
      if (pick < 10) begin
        len = $urandom_range(1, 8);
      end else if (pick < 15) begin
        len = $urandom_range(9, BLOCK - 1);
      end else if (pick < 18) begin
        len = BLOCK * $urandom_range(1, 3);
      end else begin
        len = $urandom_range(BLOCK + 1, 3 * BLOCK);
      end
      split = (len > 1 && $urandom_range(0, 11) == 0) ? $urandom_range(1, len - 1) : 0;
      for (int k = 0; k < len; k++) begin
        if (split != 0 && k == split) begin
          write_compute_b(1'($urandom_range(0, 1)));
        end
        send_random(k == len - 1);
      end
      n_items += len;
      n_rows++;
      if ($urandom_range(0, 14) == 0) begin
        write_compute_b(1'($urandom_range(0, 1)));
      end else if ($urandom_range(0, 24) == 0) begin
        settle();
      end
    end

    in_valid <= 1'b0;
    while (dot_model.pending() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    $display("Ran %0d random items over %0d rows after the directed rows.", n_items, n_rows);
    $display("Checked %0d row results; compute_b was written %0d times.",
             dot_model.rows_checked, cfg_writes);
    if (dot_model.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
